// ===== rtl/pwnc_pkg.sv =====
// package for the periodic wrap nearest centre block
// shared constants, codes, request control struct and back-end state type
// no dependencies
`default_nettype none

package pwnc_pkg;

    localparam int DEF_MAX_CENTERS = 64;
    localparam int DEF_COORD_BITS  = 24;

    localparam int BOX_BITS       = 22;
    localparam int COUNT_BITS     = 7;
    localparam int SLOT_BITS      = 6;
    localparam int SHIFT_BITS     = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 22;
    localparam int R2_BITS        = 2 * BOX_BITS;

    localparam logic [COUNT_BITS-1:0] RST_CENTER_COUNT  = COUNT_BITS'(1);
    localparam logic [BOX_BITS-1:0]   RST_BOX_SIZE      = BOX_BITS'(4194303);
    localparam logic [BOX_BITS-1:0]   RST_SPHERE_RADIUS = BOX_BITS'(0);

    localparam logic [SHIFT_BITS-1:0] SHIFT_NONE = 2'b00;
    localparam logic [SHIFT_BITS-1:0] SHIFT_UP   = 2'b01;
    localparam logic [SHIFT_BITS-1:0] SHIFT_DOWN = 2'b11;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CENTER_COUNT  = 2'd0,
        CFG_BOX_SIZE      = 2'd1,
        CFG_SPHERE_RADIUS = 2'd2
    } t_cfg_index;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_command;

    typedef struct packed {
        t_command              cmd;
        logic [SLOT_BITS-1:0]  slot;
        logic [SHIFT_BITS-1:0] shift_x;
        logic [SHIFT_BITS-1:0] shift_y;
        logic [SHIFT_BITS-1:0] shift_z;
    } t_job_ctl;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_DONE
    } t_back_state;

    // width of a wrapped coordinate, wide enough for any box size
    function automatic int wrap_bits(input int coord_bits);
        return ((coord_bits > BOX_BITS) ? coord_bits : BOX_BITS) + 1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pwnc_if.sv =====
// valid/ready channel interfaces: request in, result out, register write
// depends on pwnc_pkg
`default_nettype none

interface pwnc_in_if #(
    parameter int COORD_BITS = pwnc_pkg::DEF_COORD_BITS
) ();
    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic [pwnc_pkg::SLOT_BITS-1:0]         entry_index;
    logic signed [COORD_BITS-1:0]           coord_x;
    logic signed [COORD_BITS-1:0]           coord_y;
    logic signed [COORD_BITS-1:0]           coord_z;

    modport source (output valid, command, entry_index, coord_x, coord_y, coord_z,
                    input ready);
    modport sink (input valid, command, entry_index, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface pwnc_out_if #(
    parameter int COORD_BITS = pwnc_pkg::DEF_COORD_BITS
) ();
    logic                                   valid;
    logic                                   ready;
    logic signed [COORD_BITS-1:0]           wrapped_x;
    logic signed [COORD_BITS-1:0]           wrapped_y;
    logic signed [COORD_BITS-1:0]           wrapped_z;
    logic signed [pwnc_pkg::SHIFT_BITS-1:0] shift_x;
    logic signed [pwnc_pkg::SHIFT_BITS-1:0] shift_y;
    logic signed [pwnc_pkg::SHIFT_BITS-1:0] shift_z;
    logic [pwnc_pkg::SLOT_BITS-1:0]         closest_index;
    logic                                   inside_flag;

    modport source (output valid, wrapped_x, wrapped_y, wrapped_z, shift_x, shift_y,
                    shift_z, closest_index, inside_flag, input ready);
    modport sink (input valid, wrapped_x, wrapped_y, wrapped_z, shift_x, shift_y,
                  shift_z, closest_index, inside_flag, output ready);
endinterface

interface pwnc_cfg_if ();
    logic                                valid;
    logic                                ready;
    logic [pwnc_pkg::CFG_INDEX_BITS-1:0] index;
    logic [pwnc_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/periodic_wrap_nearest_center_top.sv =====
// top level of the periodic wrap nearest centre search
// holds the registers; depends on pwnc_pkg, pwnc_if, pwnc_front, pwnc_queue, pwnc_back
//
// channel  dir  handshake    payload
// i_in     in   valid/ready  command, entry_index, coord_x, coord_y, coord_z
// o_out    out  valid/ready  wrapped_x/y/z, shift_x/y/z, closest_index, inside_flag
// i_cfg    in   valid/ready  index, data (ready always high)
//
// a load request passes through the queue and is written to the centre table once it is
// at the queue head while the back end is idle; a query sweeps n entries, n the clamped
// centre count; the back-end sweep reads one table entry and evaluates one squared distance per cycle
// synchronous active-low reset clears control state; table contents undefined until loaded
// input stalls only when the two-entry queue is full; a result waits in the output
// register while later requests carry on
`default_nettype none

module periodic_wrap_nearest_center_top #(
    parameter int MAX_CENTERS = pwnc_pkg::DEF_MAX_CENTERS,
    parameter int COORD_BITS  = pwnc_pkg::DEF_COORD_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pwnc_in_if.sink    i_in,
    pwnc_out_if.source o_out,
    pwnc_cfg_if.sink   i_cfg
);

    localparam int WW = pwnc_pkg::wrap_bits(COORD_BITS);
    localparam int QW = $bits(pwnc_pkg::t_job_ctl) + 3 * WW;

    logic [pwnc_pkg::COUNT_BITS-1:0] r_center_count;
    logic [pwnc_pkg::BOX_BITS-1:0]   r_box_size;
    logic [pwnc_pkg::BOX_BITS-1:0]   r_sphere_radius;

    logic                 f_push, q_ready, q_valid, q_pop;
    pwnc_pkg::t_job_ctl   f_ctl;
    logic signed [WW-1:0] f_px, f_py, f_pz;
    logic [QW-1:0]        q_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_count  <= pwnc_pkg::RST_CENTER_COUNT;
            r_box_size      <= pwnc_pkg::RST_BOX_SIZE;
            r_sphere_radius <= pwnc_pkg::RST_SPHERE_RADIUS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pwnc_pkg::CFG_CENTER_COUNT: begin
                    r_center_count <= i_cfg.data[pwnc_pkg::COUNT_BITS-1:0];
                end
                pwnc_pkg::CFG_BOX_SIZE: begin
                    r_box_size <= i_cfg.data[pwnc_pkg::BOX_BITS-1:0];
                end
                pwnc_pkg::CFG_SPHERE_RADIUS: begin
                    r_sphere_radius <= i_cfg.data[pwnc_pkg::BOX_BITS-1:0];
                end
                default: begin
                    r_center_count <= r_center_count;
                end
            endcase
        end
    end

    pwnc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_box_size (r_box_size),
        .i_in       (i_in),
        .i_q_ready  (q_ready),
        .o_push     (f_push),
        .o_ctl      (f_ctl),
        .o_px       (f_px),
        .o_py       (f_py),
        .o_pz       (f_pz)
    );

    pwnc_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctl, f_px, f_py, f_pz}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    pwnc_back #(
        .MAX_CENTERS (MAX_CENTERS),
        .COORD_BITS  (COORD_BITS),
        .QW          (QW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_center_count  (r_center_count),
        .i_sphere_radius (r_sphere_radius),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_pop           (q_pop),
        .o_out           (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/pwnc_front.sv =====
// front end: accepts requests, classifies load/query, wraps query points
// depends on pwnc_pkg and pwnc_if
`default_nettype none

module pwnc_front #(
    parameter int COORD_BITS = pwnc_pkg::DEF_COORD_BITS
) (
    input  wire logic [pwnc_pkg::BOX_BITS-1:0]   i_box_size,
    pwnc_in_if.sink                              i_in,
    input  wire logic                            i_q_ready,
    output logic                                 o_push,
    output pwnc_pkg::t_job_ctl                   o_ctl,
    output logic signed [pwnc_pkg::wrap_bits(COORD_BITS)-1:0] o_px,
    output logic signed [pwnc_pkg::wrap_bits(COORD_BITS)-1:0] o_py,
    output logic signed [pwnc_pkg::wrap_bits(COORD_BITS)-1:0] o_pz
);

    localparam int WW = pwnc_pkg::wrap_bits(COORD_BITS);

    logic [pwnc_pkg::SHIFT_BITS-1:0] sh_x, sh_y, sh_z;
    logic signed [WW-1:0]            wr_x, wr_y, wr_z;

    function automatic logic signed [WW-1:0] wrap_axis(
        input  logic signed [COORD_BITS-1:0]     v,
        input  logic [pwnc_pkg::BOX_BITS-1:0]    b,
        output logic [pwnc_pkg::SHIFT_BITS-1:0]  sh
    );
        logic signed [WW:0] ve;
        logic signed [WW:0] be;
        logic signed [WW:0] res;
        ve = (WW+1)'(v);
        be = $signed((WW+1)'(b));
        if (ve > be) begin
            sh  = pwnc_pkg::SHIFT_UP;
            res = ve - be;
        end else if (ve < 0) begin
            sh  = pwnc_pkg::SHIFT_DOWN;
            res = ve + be;
        end else begin
            sh  = pwnc_pkg::SHIFT_NONE;
            res = ve;
        end
        return $signed(res[WW-1:0]);
    endfunction

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    always_comb begin
        wr_x = wrap_axis(i_in.coord_x, i_box_size, sh_x);
        wr_y = wrap_axis(i_in.coord_y, i_box_size, sh_y);
        wr_z = wrap_axis(i_in.coord_z, i_box_size, sh_z);
    end

    always_comb begin
        o_ctl.cmd  = pwnc_pkg::t_command'(i_in.command);
        o_ctl.slot = i_in.entry_index;
        if (o_ctl.cmd == pwnc_pkg::CMD_QUERY) begin
            o_ctl.shift_x = sh_x;
            o_ctl.shift_y = sh_y;
            o_ctl.shift_z = sh_z;
            o_px          = wr_x;
            o_py          = wr_y;
            o_pz          = wr_z;
        end else begin
            // load keeps the raw centre
            o_ctl.shift_x = pwnc_pkg::SHIFT_NONE;
            o_ctl.shift_y = pwnc_pkg::SHIFT_NONE;
            o_ctl.shift_z = pwnc_pkg::SHIFT_NONE;
            o_px          = WW'(i_in.coord_x);
            o_py          = WW'(i_in.coord_y);
            o_pz          = WW'(i_in.coord_z);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pwnc_queue.sv =====
// two-entry request queue between front and back end
// depends on nothing but the clock and reset
`default_nettype none

module pwnc_queue #(
    parameter int W = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [W-1:0]      o_data,
    input  wire logic         i_pop
);

    localparam int DEPTH = 2;

    logic [W-1:0] r_mem [DEPTH];
    logic         r_wr_ptr, n_wr_ptr;
    logic         r_rd_ptr, n_rd_ptr;
    logic [1:0]   r_count, n_count;

    assign o_ready = (r_count != 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pwnc_back.sv =====
// back end: centre table, pipelined distance sweep, result register
// depends on pwnc_pkg and pwnc_if
`default_nettype none

module pwnc_back #(
    parameter int MAX_CENTERS = pwnc_pkg::DEF_MAX_CENTERS,
    parameter int COORD_BITS  = pwnc_pkg::DEF_COORD_BITS,
    parameter int QW          = 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [pwnc_pkg::COUNT_BITS-1:0]    i_center_count,
    input  wire logic [pwnc_pkg::BOX_BITS-1:0]      i_sphere_radius,
    input  wire logic                               i_q_valid,
    input  wire logic [QW-1:0]                      i_q_data,
    output logic                                    o_pop,
    pwnc_out_if.source                              o_out
);

    localparam int WW = pwnc_pkg::wrap_bits(COORD_BITS);
    localparam int AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CW = $clog2(MAX_CENTERS + 1);
    localparam int NW = (CW > pwnc_pkg::COUNT_BITS) ? CW : pwnc_pkg::COUNT_BITS;
    localparam int XW = AW + pwnc_pkg::SLOT_BITS;
    localparam int PW = 2 * WW;
    localparam int SW = PW + 2;
    localparam int TW = 3 * COORD_BITS;

    // queue head
    pwnc_pkg::t_job_ctl   job_ctl;
    logic signed [WW-1:0] job_px, job_py, job_pz;
    assign {job_ctl, job_px, job_py, job_pz} = i_q_data;

    pwnc_pkg::t_back_state r_state, n_state;

    logic          issue, mem_we, out_load, pipe_busy, slot_ok;
    logic [XW-1:0] slot_ext, best_ext;
    logic [NW-1:0] cnt_ext, n_sel;
    logic [CW-1:0] n_clamp;

    logic [TW-1:0] r_mem [MAX_CENTERS];
    logic [TW-1:0] r_rd_data;

    logic [CW-1:0]         r_addr, r_n;
    logic signed [WW-1:0]  r_px, r_py, r_pz;
    pwnc_pkg::t_job_ctl    r_ctl;

    logic                  r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic [AW-1:0]         r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx;
    logic signed [WW:0]    r_dx, r_dy, r_dz;
    logic [PW-1:0]         r_qx, r_qy, r_qz;
    logic [SW-1:0]         r_sum, r_best_d;
    logic [AW-1:0]         r_best_idx;
    logic [pwnc_pkg::R2_BITS-1:0] r_r2, r2_calc;

    logic signed [COORD_BITS-1:0] rd_cx, rd_cy, rd_cz;
    logic signed [2*WW+1:0]       sq_x, sq_y, sq_z;

    logic                                   r_ovalid;
    logic signed [COORD_BITS-1:0]           r_o_wx, r_o_wy, r_o_wz;
    logic [pwnc_pkg::SHIFT_BITS-1:0]        r_o_sx, r_o_sy, r_o_sz;
    logic [pwnc_pkg::SLOT_BITS-1:0]         r_o_idx;
    logic                                   r_o_inside;

    // slot range and count clamp
    always_comb begin
        slot_ext = XW'(job_ctl.slot);
        slot_ok  = (slot_ext < XW'(MAX_CENTERS));
        cnt_ext  = NW'(i_center_count);
        if (cnt_ext == '0) begin
            n_sel = NW'(1);
        end else if (cnt_ext > NW'(MAX_CENTERS)) begin
            n_sel = NW'(MAX_CENTERS);
        end else begin
            n_sel = cnt_ext;
        end
        n_clamp  = n_sel[CW-1:0];
        best_ext = XW'(r_best_idx);
    end

    assign pipe_busy = r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pwnc_pkg::BK_IDLE: begin
                if (i_q_valid && job_ctl.cmd == pwnc_pkg::CMD_QUERY) begin
                    n_state = pwnc_pkg::BK_SEARCH;
                end
            end
            pwnc_pkg::BK_SEARCH: begin
                if (!(r_addr < r_n) && !pipe_busy) begin
                    n_state = pwnc_pkg::BK_DONE;
                end
            end
            pwnc_pkg::BK_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = pwnc_pkg::BK_IDLE;
                end
            end
            default: n_state = pwnc_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            pwnc_pkg::BK_IDLE: begin
                o_pop  = i_q_valid;
                mem_we = i_q_valid && job_ctl.cmd == pwnc_pkg::CMD_LOAD && slot_ok;
            end
            pwnc_pkg::BK_SEARCH: begin
                issue = (r_addr < r_n);
            end
            pwnc_pkg::BK_DONE: begin
                out_load = !r_ovalid || o_out.ready;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pwnc_pkg::BK_IDLE;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // centre table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[slot_ext[AW-1:0]] <= {job_px[COORD_BITS-1:0], job_py[COORD_BITS-1:0],
                                        job_pz[COORD_BITS-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_addr[AW-1:0]];
    end

    always_comb begin
        rd_cx   = $signed(r_rd_data[3*COORD_BITS-1:2*COORD_BITS]);
        rd_cy   = $signed(r_rd_data[2*COORD_BITS-1:COORD_BITS]);
        rd_cz   = $signed(r_rd_data[COORD_BITS-1:0]);
        sq_x    = r_dx * r_dx;
        sq_y    = r_dy * r_dy;
        sq_z    = r_dz * r_dz;
        r2_calc = i_sphere_radius * i_sphere_radius;
    end

    // query capture and sweep datapath
    always_ff @(posedge i_clk) begin
        if (o_pop && job_ctl.cmd == pwnc_pkg::CMD_QUERY) begin
            r_px   <= job_px;
            r_py   <= job_py;
            r_pz   <= job_pz;
            r_ctl  <= job_ctl;
            r_addr <= '0;
            r_n    <= n_clamp;
        end else if (issue) begin
            r_addr <= r_addr + CW'(1);
        end

        r_r2     <= r2_calc;
        r_s1_idx <= r_addr[AW-1:0];

        r_s2_idx <= r_s1_idx;
        r_dx     <= (WW+1)'(r_px) - (WW+1)'(rd_cx);
        r_dy     <= (WW+1)'(r_py) - (WW+1)'(rd_cy);
        r_dz     <= (WW+1)'(r_pz) - (WW+1)'(rd_cz);

        r_s3_idx <= r_s2_idx;
        r_qx     <= sq_x[PW-1:0];
        r_qy     <= sq_y[PW-1:0];
        r_qz     <= sq_z[PW-1:0];

        r_s4_idx <= r_s3_idx;
        r_sum    <= SW'(r_qx) + SW'(r_qy) + SW'(r_qz);

        // earliest index wins on ties
        if (r_s4_vld && (r_s4_idx == '0 || r_sum < r_best_d)) begin
            r_best_d   <= r_sum;
            r_best_idx <= r_s4_idx;
        end

        if (out_load) begin
            r_o_wx     <= $signed(r_px[COORD_BITS-1:0]);
            r_o_wy     <= $signed(r_py[COORD_BITS-1:0]);
            r_o_wz     <= $signed(r_pz[COORD_BITS-1:0]);
            r_o_sx     <= r_ctl.shift_x;
            r_o_sy     <= r_ctl.shift_y;
            r_o_sz     <= r_ctl.shift_z;
            r_o_idx    <= best_ext[pwnc_pkg::SLOT_BITS-1:0];
            r_o_inside <= (r_best_d < SW'(r_r2));
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.wrapped_x     = r_o_wx;
    assign o_out.wrapped_y     = r_o_wy;
    assign o_out.wrapped_z     = r_o_wz;
    assign o_out.shift_x       = $signed(r_o_sx);
    assign o_out.shift_y       = $signed(r_o_sy);
    assign o_out.shift_z       = $signed(r_o_sz);
    assign o_out.closest_index = r_o_idx;
    assign o_out.inside_flag   = r_o_inside;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for periodic_wrap_nearest_center_top: directed then random load and
// query requests, results checked in order against a nearest-centre predictor kept in the bench
// depends on pwnc_pkg, the pwnc_if interfaces and the block's rtl

module testbench;

    localparam int N_SLOTS = pwnc_pkg::DEF_MAX_CENTERS;
    localparam int CW      = pwnc_pkg::DEF_COORD_BITS;

    localparam logic [pwnc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

    localparam longint COORD_HI = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_LO = -(longint'(1) << (CW - 1));

    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_CYCLES     = 600;
    localparam int STALL_LIMIT     = 5000;
    localparam int MAX_REPORTS     = 10;
    localparam int GAP_PCT         = 12;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 210;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        pwnc_pkg::t_command             cmd;
        logic [pwnc_pkg::SLOT_BITS-1:0] slot;
        t_coord                         x;
        t_coord                         y;
        t_coord                         z;
    } t_request;

    typedef struct packed {
        t_coord                          wx;
        t_coord                          wy;
        t_coord                          wz;
        logic [pwnc_pkg::SHIFT_BITS-1:0] sx;
        logic [pwnc_pkg::SHIFT_BITS-1:0] sy;
        logic [pwnc_pkg::SHIFT_BITS-1:0] sz;
        logic [pwnc_pkg::SLOT_BITS-1:0]  idx;
        logic                            in_sphere;
    } t_answer;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pwnc_in_if  #(.COORD_BITS(CW)) req_ch ();
    pwnc_out_if #(.COORD_BITS(CW)) ans_ch ();
    pwnc_cfg_if                    reg_ch ();

    periodic_wrap_nearest_center_top #(
        .MAX_CENTERS(N_SLOTS),
        .COORD_BITS (CW)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (ans_ch),
        .i_cfg  (reg_ch)
    );

    t_request request_queue[$];
    t_answer  awaited[$];
    int       errors = 0;
    int       quiet_cycles = 0;
    int       hold_left = 0;
    bit       no_gaps = 1'b0;
    bit       squeeze = 1'b0;
    bit       squeeze_done = 1'b0;

    // predictor copy of table and registers, updated on accepted requests
    t_coord                          tbl_x[N_SLOTS];
    t_coord                          tbl_y[N_SLOTS];
    t_coord                          tbl_z[N_SLOTS];
    logic [pwnc_pkg::COUNT_BITS-1:0] pred_count  = pwnc_pkg::RST_CENTER_COUNT;
    logic [pwnc_pkg::BOX_BITS-1:0]   pred_box    = pwnc_pkg::RST_BOX_SIZE;
    logic [pwnc_pkg::BOX_BITS-1:0]   pred_radius = pwnc_pkg::RST_SPHERE_RADIUS;

    // stimulus side view of what has been queued
    bit [N_SLOTS-1:0]              planned = '0;
    t_coord                        plan_x[N_SLOTS];
    t_coord                        plan_y[N_SLOTS];
    t_coord                        plan_z[N_SLOTS];
    int                            gen_count  = 1;
    logic [pwnc_pkg::BOX_BITS-1:0] gen_box    = pwnc_pkg::RST_BOX_SIZE;
    logic [pwnc_pkg::BOX_BITS-1:0] gen_radius = pwnc_pkg::RST_SPHERE_RADIUS;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int searched_count(input logic [pwnc_pkg::COUNT_BITS-1:0] c);
        if (c == 0) begin
            return 1;
        end
        return (c > N_SLOTS) ? N_SLOTS : int'(c);
    endfunction

    function automatic void wrap_axis(input t_coord v, output t_coord w,
                                      output logic [pwnc_pkg::SHIFT_BITS-1:0] s);
        longint lv;
        longint lb;
        lv = v;
        lb = longint'(pred_box);
        if (lv > lb) begin
            w = t_coord'(lv - lb);
            s = pwnc_pkg::SHIFT_UP;
        end else if (lv < 0) begin
            w = t_coord'(lv + lb);
            s = pwnc_pkg::SHIFT_DOWN;
        end else begin
            w = v;
            s = pwnc_pkg::SHIFT_NONE;
        end
    endfunction

    function automatic longint dist_sq(input t_coord px, input t_coord py, input t_coord pz,
                                       input int k);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(px) - longint'(tbl_x[k]);
        dy = longint'(py) - longint'(tbl_y[k]);
        dz = longint'(pz) - longint'(tbl_z[k]);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    function automatic t_answer nearest_centre(input t_request r);
        t_answer a;
        int      n;
        int      k;
        longint  best_d;
        longint  d;
        wrap_axis(r.x, a.wx, a.sx);
        wrap_axis(r.y, a.wy, a.sy);
        wrap_axis(r.z, a.wz, a.sz);
        n = searched_count(pred_count);
        a.idx = '0;
        best_d = dist_sq(a.wx, a.wy, a.wz, 0);
        for (k = 1; k < n; k++) begin
            d = dist_sq(a.wx, a.wy, a.wz, k);
            if (d < best_d) begin
                best_d = d;
                a.idx = k[pwnc_pkg::SLOT_BITS-1:0];
            end
        end
        a.in_sphere = (best_d < longint'(pred_radius) * longint'(pred_radius));
        return a;
    endfunction

    function automatic t_coord clip(input longint v);
        if (v > COORD_HI) begin
            return t_coord'(COORD_HI);
        end
        if (v < COORD_LO) begin
            return t_coord'(COORD_LO);
        end
        return t_coord'(v);
    endfunction

    // 0 full range, 1 corner values, otherwise around the box
    function automatic t_coord rand_coord(input int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: begin
                case ($urandom_range(6))
                    0: return t_coord'(COORD_HI);
                    1: return t_coord'(COORD_LO);
                    2: return t_coord'(0);
                    3: return t_coord'(-1);
                    4: return t_coord'(1);
                    5: return t_coord'(longint'(gen_box));
                    default: return t_coord'(longint'(gen_box) + 1);
                endcase
            end
            default: return clip(longint'($urandom_range(gen_box + 64)) - 32);
        endcase
    endfunction

    function automatic int coord_mode(input int pick);
        if (pick < 70) begin
            return 2;
        end
        return (pick < 88) ? 0 : 1;
    endfunction

    task automatic queue_load(input int slot, input t_coord x, input t_coord y, input t_coord z);
        t_request r;
        r.cmd  = pwnc_pkg::CMD_LOAD;
        r.slot = slot[pwnc_pkg::SLOT_BITS-1:0];
        r.x    = x;
        r.y    = y;
        r.z    = z;
        request_queue.insert(request_queue.size(), r);
        planned[slot] = 1'b1;
        plan_x[slot]  = x;
        plan_y[slot]  = y;
        plan_z[slot]  = z;
    endtask

    task automatic queue_query(input t_coord x, input t_coord y, input t_coord z);
        t_request r;
        r.cmd  = pwnc_pkg::CMD_QUERY;
        r.slot = pwnc_pkg::SLOT_BITS'($urandom);
        r.x    = x;
        r.y    = y;
        r.z    = z;
        request_queue.insert(request_queue.size(), r);
    endtask

    task automatic queue_random_load();
        int slot;
        int src;
        slot = $urandom_range(N_SLOTS - 1);
        src  = $urandom_range(N_SLOTS - 1);
        if ($urandom_range(99) < 8 && planned[src]) begin
            // duplicate centre, gives distance ties
            queue_load(slot, plan_x[src], plan_y[src], plan_z[src]);
        end else begin
            queue_load(slot, rand_coord(coord_mode($urandom_range(99))),
                       rand_coord(coord_mode($urandom_range(99))),
                       rand_coord(coord_mode($urandom_range(99))));
        end
    endtask

    task automatic queue_random_query();
        int     k;
        longint spread;
        if ($urandom_range(99) < 55) begin
            k = $urandom_range(gen_count - 1);
            spread = longint'(gen_radius) + 2;
            queue_query(clip(plan_x[k] + longint'($urandom_range(2 * spread)) - spread),
                        clip(plan_y[k] + longint'($urandom_range(2 * spread)) - spread),
                        clip(plan_z[k] + longint'($urandom_range(2 * spread)) - spread));
        end else begin
            queue_query(rand_coord(coord_mode($urandom_range(99))),
                        rand_coord(coord_mode($urandom_range(99))),
                        rand_coord(coord_mode($urandom_range(99))));
        end
    endtask

    // wait for the block to drain, then allow for a load still in flight
    task automatic settle();
        while (request_queue.size() != 0 || req_ch.valid || awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [pwnc_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [pwnc_pkg::CFG_DATA_BITS-1:0] val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= val;
        do @(posedge i_clk); while (!reg_ch.ready);
        reg_ch.valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            pwnc_pkg::CFG_CENTER_COUNT:
                gen_count  = searched_count(val[pwnc_pkg::COUNT_BITS-1:0]);
            pwnc_pkg::CFG_BOX_SIZE:      gen_box    = val[pwnc_pkg::BOX_BITS-1:0];
            pwnc_pkg::CFG_SPHERE_RADIUS: gen_radius = val[pwnc_pkg::BOX_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [pwnc_pkg::CFG_DATA_BITS-1:0] count,
                             input logic [pwnc_pkg::CFG_DATA_BITS-1:0] box,
                             input logic [pwnc_pkg::CFG_DATA_BITS-1:0] radius);
        int k;
        settle();
        write_register(CFG_SPARE, pwnc_pkg::CFG_DATA_BITS'($urandom));
        write_register(pwnc_pkg::CFG_CENTER_COUNT, count);
        write_register(pwnc_pkg::CFG_BOX_SIZE, box);
        write_register(pwnc_pkg::CFG_SPHERE_RADIUS, radius);
        // every searched slot must hold a centre before any query
        for (k = 0; k < gen_count; k++) begin
            if (!planned[k]) begin
                queue_load(k, rand_coord(2), rand_coord(2), rand_coord(2));
            end
        end
    endtask

    function automatic logic [pwnc_pkg::CFG_DATA_BITS-1:0] random_box();
        if ($urandom_range(1)) begin
            return pwnc_pkg::CFG_DATA_BITS'($urandom_range(1, 4096));
        end
        return pwnc_pkg::CFG_DATA_BITS'($urandom_range(1, 4194303));
    endfunction

    function automatic logic [pwnc_pkg::CFG_DATA_BITS-1:0] random_count();
        if ($urandom_range(99) < 70) begin
            return pwnc_pkg::CFG_DATA_BITS'($urandom_range(1, 8));
        end
        return pwnc_pkg::CFG_DATA_BITS'($urandom_range(1, N_SLOTS));
    endfunction

    // request driver
    always @(posedge i_clk) begin : feed_requests
        t_request nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (request_queue.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
                nxt = request_queue.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.command     <= nxt.cmd;
                req_ch.entry_index <= nxt.slot;
                req_ch.coord_x     <= nxt.x;
                req_ch.coord_y     <= nxt.y;
                req_ch.coord_z     <= nxt.z;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result acceptance, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ans_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            ans_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
            if (hold_left == 1) begin
                squeeze_done <= 1'b1;
            end
        end else if (squeeze && !squeeze_done) begin
            ans_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
        end else begin
            ans_ch.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
        end
    end

    // track register writes and accepted requests
    always @(posedge i_clk) begin : track_requests
        t_request seen;
        if (i_rst_n) begin
            if (reg_ch.valid && reg_ch.ready) begin
                case (reg_ch.index)
                    pwnc_pkg::CFG_CENTER_COUNT:
                        pred_count  = reg_ch.data[pwnc_pkg::COUNT_BITS-1:0];
                    pwnc_pkg::CFG_BOX_SIZE:
                        pred_box    = reg_ch.data[pwnc_pkg::BOX_BITS-1:0];
                    pwnc_pkg::CFG_SPHERE_RADIUS:
                        pred_radius = reg_ch.data[pwnc_pkg::BOX_BITS-1:0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready) begin
                seen.cmd  = pwnc_pkg::t_command'(req_ch.command);
                seen.slot = req_ch.entry_index;
                seen.x    = req_ch.coord_x;
                seen.y    = req_ch.coord_y;
                seen.z    = req_ch.coord_z;
                if (seen.cmd == pwnc_pkg::CMD_LOAD) begin
                    tbl_x[seen.slot] = seen.x;
                    tbl_y[seen.slot] = seen.y;
                    tbl_z[seen.slot] = seen.z;
                end else begin
                    awaited.insert(awaited.size(), nearest_centre(seen));
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_answers
        t_answer got;
        t_answer want;
        if (i_rst_n && ans_ch.valid && ans_ch.ready) begin
            got.wx        = ans_ch.wrapped_x;
            got.wy        = ans_ch.wrapped_y;
            got.wz        = ans_ch.wrapped_z;
            got.sx        = ans_ch.shift_x;
            got.sy        = ans_ch.shift_y;
            got.sz        = ans_ch.shift_z;
            got.idx       = ans_ch.closest_index;
            got.in_sphere = ans_ch.inside_flag;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected result: wrapped %0d %0d %0d index %0d inside %0b",
                             got.wx, got.wy, got.wz, got.idx, got.in_sphere);
                end
            end else begin
                want = awaited.pop_front();
                if (got.wx !== want.wx || got.wy !== want.wy || got.wz !== want.wz ||
                    got.sx !== want.sx || got.sy !== want.sy || got.sz !== want.sz ||
                    got.idx !== want.idx || got.in_sphere !== want.in_sphere) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: expected wrapped %0d %0d %0d shift %b %b %b",
                                 want.wx, want.wy, want.wz, want.sx, want.sy, want.sz,
                                 " idx %0d in %b", want.idx, want.in_sphere);
                        $display("          actual   wrapped %0d %0d %0d shift %b %b %b",
                                 got.wx, got.wy, got.wz, got.sx, got.sy, got.sz,
                                 " idx %0d in %b", got.idx, got.in_sphere);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (ans_ch.valid && ans_ch.ready) ||
            (reg_ch.valid && reg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[periodic_wrap_nearest_center_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int ph;
        int i;
        req_ch.valid       = 1'b0;
        req_ch.command     = pwnc_pkg::CMD_LOAD;
        req_ch.entry_index = '0;
        req_ch.coord_x     = '0;
        req_ch.coord_y     = '0;
        req_ch.coord_z     = '0;
        reg_ch.valid       = 1'b0;
        reg_ch.index       = '0;
        reg_ch.data        = '0;
        ans_ch.ready       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one centre, widest box, zero radius
        queue_load(0, 0, 0, 0);
        queue_query(0, 0, 0);
        queue_query(t_coord'(4194303), t_coord'(4194304), t_coord'(-1));
        queue_query(t_coord'(COORD_HI), t_coord'(COORD_LO), 0);
        queue_load(N_SLOTS - 1, t_coord'(COORD_HI), t_coord'(COORD_LO), t_coord'(-1));

        // zero count and zero box
        configure(22'd0, 22'd0, 22'd5);
        queue_query(5, -5, 0);
        queue_query(3, 0, 0);
        queue_query(0, 0, 0);

        // equal distances pick the lower slot, sphere surface is outside
        queue_load(1, 10, 0, 0);
        queue_load(2, 10, 0, 0);
        configure(22'd3, 22'(pwnc_pkg::RST_BOX_SIZE), 22'd5);
        queue_query(5, 0, 0);
        queue_query(8, 0, 0);
        queue_query(4, 0, 0);

        // smallest box, values on and past its edges
        configure(22'd3, 22'd1, 22'd0);
        queue_query(1, 2, -1);
        queue_query(0, 1, t_coord'(COORD_LO));

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(22'd64, 22'(pwnc_pkg::RST_BOX_SIZE), 22'd0);
                1: configure(22'h3FFFFF, 22'd1, 22'h3FFFFF);
                2: configure(22'd0, 22'd0,
                             pwnc_pkg::CFG_DATA_BITS'($urandom_range(0, 1000)));
                3: configure(22'd100, random_box(), pwnc_pkg::CFG_DATA_BITS'($urandom));
                default: configure(random_count(), random_box(),
                                   pwnc_pkg::CFG_DATA_BITS'($urandom_range(0, gen_box)));
            endcase
            if (ph == 2) begin
                squeeze <= 1'b1;
            end
            no_gaps <= (ph == 3);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(99) < 25) begin
                    queue_random_load();
                end else begin
                    queue_random_query();
                end
            end
        end

        settle();
        if (errors == 0 && awaited.size() == 0) begin
            $display("[periodic_wrap_nearest_center_top] OK");
        end else begin
            $display("[periodic_wrap_nearest_center_top] ERROR");
        end
        $finish;
    end

endmodule
